// ===== rtl/nrr_pkg.sv =====
// ----------------------------------------------------------------------------
// nrr_pkg
// Shared types and constants for the note release retrigger block.
// ----------------------------------------------------------------------------
package nrr_pkg;

    // Field widths of the stream items.
    localparam int KIND_W  = 2;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int TIME_W  = 40;
    localparam int DATA_W  = 56;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;
    localparam int REP_W   = 4;

    // Input event kinds.
    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;

    // Result kinds.
    localparam logic OUT_NOTE_ON  = 1'b0;
    localparam logic OUT_NOTE_OFF = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_REPEAT_COUNT    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_VELOCITY_OFFSET = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FADE_MODE       = 2'd2;

    localparam logic [REP_W-1:0] MAX_REPEATS = 4'd8;
    localparam logic [VEL_W-1:0] VEL_MAX     = 7'd127;

    // Control of the note table for one accepted item.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tbl_ctl;

    // Adds a signed offset to a velocity and clamps the sum to 0..127.
    function automatic logic [VEL_W-1:0] add_clamp(input logic [VEL_W-1:0] vel,
                                                   input logic signed [CFG_W-1:0] off);
        logic signed [VEL_W+1:0] sum;
        sum = $signed({2'b00, vel}) + $signed({off[CFG_W-1], off});
        if (sum < 0) begin
            return '0;
        end else if (sum > $signed({2'b00, VEL_MAX})) begin
            return VEL_MAX;
        end else begin
            return sum[VEL_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/nrr_table.sv =====
// ----------------------------------------------------------------------------
// nrr_table
// Per-note table of velocity and press time, with a valid bit per note so
// that a note never pressed reads as velocity zero and time zero.
// ----------------------------------------------------------------------------
module nrr_table
    import nrr_pkg::*;
#(
    parameter int NOTE_COUNT = 128,
    parameter int TIME_BITS  = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tbl_ctl                i_ctl,
    input  logic [((NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1)-1:0] i_addr,
    input  logic [VEL_W-1:0]        i_wr_vel,
    input  logic [TIME_BITS-1:0]    i_wr_time,
    output logic [VEL_W-1:0]        o_rd_vel,
    output logic [TIME_BITS-1:0]    o_rd_time
);

    logic [VEL_W-1:0]     r_mem_vel  [NOTE_COUNT];
    logic [TIME_BITS-1:0] r_mem_time [NOTE_COUNT];
    logic [NOTE_COUNT-1:0] r_vld;
    logic [VEL_W-1:0]     r_rd_vel;
    logic [TIME_BITS-1:0] r_rd_time;
    logic                 r_rd_hit;

    // Storage: one write or one read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_vel[i_addr]  <= i_wr_vel;
            r_mem_time[i_addr] <= i_wr_time;
        end
        if (i_ctl.rd_en) begin
            r_rd_vel  <= r_mem_vel[i_addr];
            r_rd_time <= r_mem_time[i_addr];
        end
    end

    // Valid bits are cleared by reset and set when a note is first pressed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_hit <= r_vld[i_addr];
            end
        end
    end

    // An entry never written reads as zero.
    assign o_rd_vel  = r_rd_hit ? r_rd_vel  : '0;
    assign o_rd_time = r_rd_hit ? r_rd_time : '0;

endmodule

// ===== rtl/note_release_retrigger.sv =====
// ----------------------------------------------------------------------------
// note_release_retrigger
// Turns each note release into a run of re-triggered note-on/note-off pairs.
// ----------------------------------------------------------------------------
// A note-on item only updates the per-note table (out-of-range notes are
// ignored); it produces no result. An in-range note-off item produces
// 2 + 2*min(repeat_count, 8) results, between 2 and 18, delivered one per
// cycle from the output register, which steps through the run while the
// downstream side takes them. Items stream in at one per cycle while the
// input stage is empty or is handing its note-off to the generator. A
// note-off that waits for the generator sits in that single input stage,
// and while it waits the input side stalls for every item, note-on or
// note-off, until the run ahead has sent its last result. The generator
// therefore sets the sustained rate. The table's valid bits are cleared by
// reset, so there is no clearing pass. The user must write configuration
// only while no run is in progress; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module note_release_retrigger
    import nrr_pkg::*;
#(
    parameter int NOTE_COUNT = 128,
    parameter int TIME_BITS  = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    // Input items.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,   // note_number, note_velocity, event_time
    input  logic [KIND_W-1:0]   s_axis_tuser,   // event_kind
    // Result items.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,   // out_note, out_velocity, out_time
    output logic [0:0]          m_axis_tuser,   // out_kind
    output logic                m_axis_tlast    // last_of_run
);

    localparam int NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

    // Configuration registers.
    logic [REP_W-1:0]        r_repeat_count;
    logic signed [CFG_W-1:0] r_vel_offset;
    logic                    r_fade_mode;

    // Input stage holding a note-off that waits for the generator.
    logic                 r_s1_valid;
    logic [NOTE_W-1:0]    r_s1_note;
    logic [TIME_BITS-1:0] r_s1_time;

    // Output register and run state.
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [NOTE_W-1:0]    r_out_note;
    logic [VEL_W-1:0]     r_out_vel;
    logic [TIME_BITS-1:0] r_out_time;
    logic                 r_out_last;
    logic [TIME_BITS-1:0] r_len;
    logic [REP_W-1:0]     r_pairs_left;

    logic                 n_out_valid;
    logic                 n_out_kind;
    logic [NOTE_W-1:0]    n_out_note;
    logic [VEL_W-1:0]     n_out_vel;
    logic [TIME_BITS-1:0] n_out_time;
    logic                 n_out_last;
    logic [TIME_BITS-1:0] n_len;
    logic [REP_W-1:0]     n_pairs_left;

    logic [KIND_W-1:0]    in_kind;
    logic [NOTE_W-1:0]    in_note;
    logic [VEL_W-1:0]     in_vel;
    logic [63:0]          in_time_64;
    logic [TIME_BITS-1:0] in_time;
    logic                 in_range;
    logic                 in_acc;
    logic                 pop;
    logic                 gen_free;
    logic                 s1_take;
    logic [REP_W-1:0]     reps_sat;
    t_tbl_ctl             tbl_ctl;
    logic [VEL_W-1:0]     rd_vel;
    logic [TIME_BITS-1:0] rd_time;
    logic [63:0]          out_time_64;

    // Unpack the input item.
    assign in_kind    = s_axis_tuser;
    assign in_note    = s_axis_tdata[NOTE_W-1:0];
    assign in_vel     = s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];
    assign in_time_64 = 64'(s_axis_tdata[NOTE_W+VEL_W+TIME_W-1:NOTE_W+VEL_W]);
    assign in_time    = in_time_64[TIME_BITS-1:0];
    assign in_range   = ({1'b0, in_note} < 8'(NOTE_COUNT));

    // Handshake and hand-over between the stages.
    assign pop           = r_out_valid && m_axis_tready;
    assign gen_free      = !r_out_valid || (pop && r_out_last);
    assign s1_take       = r_s1_valid && gen_free;
    assign s_axis_tready = !r_s1_valid || s1_take;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Table access: note-on writes, note-off reads, out-of-range notes do nothing.
    assign tbl_ctl.wr_en = in_acc && in_range && (in_kind == KIND_NOTE_ON);
    assign tbl_ctl.rd_en = in_acc && in_range && (in_kind == KIND_NOTE_OFF);

    nrr_table #(
        .NOTE_COUNT (NOTE_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_addr    (in_note[NW-1:0]),
        .i_wr_vel  (in_vel),
        .i_wr_time (in_time),
        .o_rd_vel  (rd_vel),
        .o_rd_time (rd_time)
    );

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_count <= '0;
            r_vel_offset   <= '0;
            r_fade_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REPEAT_COUNT:    r_repeat_count <= i_cfg_wdata[REP_W-1:0];
                CFG_VELOCITY_OFFSET: r_vel_offset   <= $signed(i_cfg_wdata);
                CFG_FADE_MODE:       r_fade_mode    <= i_cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    // Input stage: only in-range note-offs need the generator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (tbl_ctl.rd_en) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_ctl.rd_en) begin
            r_s1_note <= in_note;
            r_s1_time <= in_time;
        end
    end

    assign reps_sat = (r_repeat_count > MAX_REPEATS) ? MAX_REPEATS : r_repeat_count;

    // Result generator: start a run, or step to the next result on a pop.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_note   = r_out_note;
        n_out_vel    = r_out_vel;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;
        n_len        = r_len;
        n_pairs_left = r_pairs_left;
        if (s1_take) begin
            n_out_valid  = 1'b1;
            n_out_kind   = OUT_NOTE_ON;
            n_out_note   = r_s1_note;
            n_out_vel    = add_clamp(rd_vel, r_vel_offset);
            n_out_time   = r_s1_time;
            n_out_last   = 1'b0;
            n_len        = r_s1_time - rd_time;
            n_pairs_left = reps_sat;
        end else if (pop) begin
            if (r_out_last) begin
                n_out_valid = 1'b0;
            end else if (r_out_kind == OUT_NOTE_ON) begin
                n_out_kind = OUT_NOTE_OFF;
                n_out_time = r_out_time + r_len;
                n_out_last = (r_pairs_left == '0);
            end else begin
                n_out_kind   = OUT_NOTE_ON;
                n_out_vel    = r_fade_mode ? add_clamp(r_out_vel, r_vel_offset) : r_out_vel;
                n_pairs_left = r_pairs_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind   <= n_out_kind;
        r_out_note   <= n_out_note;
        r_out_vel    <= n_out_vel;
        r_out_time   <= n_out_time;
        r_out_last   <= n_out_last;
        r_len        <= n_len;
        r_pairs_left <= n_pairs_left;
    end

    // Pack the result item.
    assign out_time_64   = 64'(r_out_time);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, out_time_64[TIME_W-1:0], r_out_vel, r_out_note};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // A run never ends on a note-on.
    a_last_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_kind == OUT_NOTE_OFF)
        else $error("run ends on a note-on");

    // The repeat counter stays within the saturated range during a run.
    a_pairs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_pairs_left <= MAX_REPEATS)
        else $error("repeat counter out of range");

    // A taken note-on is followed by its note-off, one length later, same velocity.
    a_on_then_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && r_out_kind == OUT_NOTE_ON |=> r_out_valid && r_out_kind == OUT_NOTE_OFF
        && r_out_time == $past(r_out_time + r_len) && r_out_vel == $past(r_out_vel))
        else $error("note-off does not follow its note-on");

    // A taken note-off that is not last is followed by a note-on at the same time.
    a_off_then_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && r_out_kind == OUT_NOTE_OFF && !r_out_last |=> r_out_valid
        && r_out_kind == OUT_NOTE_ON && r_out_time == $past(r_out_time))
        else $error("repeat pair does not start where the last one ended");
`endif

endmodule
